[hdl/btdm_pkg.sv]
// shared constants for the binary template digit matcher
// command codes, field widths, register indexes and reset values; no dependencies
package btdm_pkg;

	localparam int CELL_SIZE_DEF    = 64;
	localparam int MAX_TMPL_DEF     = 64;
	localparam int NUM_DIGITS_DEF   = 9;

	localparam int CMD_W            = 2;
	localparam int DIGIT_W          = 4;
	localparam int IDX_W            = 12;
	localparam int COORD_W          = 6;
	localparam int PIX_W            = 8;
	localparam int SCORE_W          = 13;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 13;
	localparam int THR_W            = 8;
	localparam int MARGIN_W         = 7;
	localparam int SIZE_W           = 7;

	localparam logic [CMD_W-1:0] CMD_LOAD_TMPL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_CELL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET_ORDER = 2'd2;
	localparam logic [CMD_W-1:0] CMD_MATCH     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLS      = 3'd4;

	localparam logic [THR_W-1:0]    THRESHOLD_RST = 8'd50;
	localparam logic [MARGIN_W-1:0] MARGIN_RST    = 7'd40;
	localparam logic [SCORE_W-1:0]  ACCEPT_RST    = 13'd3000;
	localparam logic [SIZE_W-1:0]   ROWS_RST      = 7'd48;
	localparam logic [SIZE_W-1:0]   COLS_RST      = 7'd48;

	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

endpackage

[hdl/binary_template_digit_matcher_unit.sv]
// binary template digit matcher top level, one shared pixel compare unit; depends on btdm_pkg
// sequence: load and set-order beats are written when accepted; a blank or no-position match goes
// straight to done, a full match scans each position of every searched template (pixel, drain, eval)
//   until an early accept; done registers the result, and a held result keeps the unit in that state
// throughput: one beat at a time, input stalled while a match runs; loads go on while a result waits
// reset: control, registers and candidate list return to defaults; the stores are not cleared
module binary_template_digit_matcher_unit #(
	parameter int CELL_SIZE         = btdm_pkg::CELL_SIZE_DEF,
	parameter int MAX_TEMPLATE_SIZE = btdm_pkg::MAX_TMPL_DEF,
	parameter int NUM_DIGITS        = btdm_pkg::NUM_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [btdm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [btdm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [btdm_pkg::CMD_W-1:0]         command,
	input  logic [btdm_pkg::DIGIT_W-1:0]       digit,
	input  logic [btdm_pkg::IDX_W-1:0]         pixel_index,
	input  logic [btdm_pkg::PIX_W-1:0]         pixel_value,
	input  logic [4*NUM_DIGITS-1:0]            candidate_order,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [btdm_pkg::DIGIT_W-1:0]       best_digit,
	output logic [btdm_pkg::SCORE_W-1:0]       best_score,
	output logic                               accepted_early
);
	import btdm_pkg::*;

	localparam int CANVAS = 3 * CELL_SIZE;
	localparam int PW     = $clog2(CANVAS + 130) + 1;
	localparam int TDEPTH = NUM_DIGITS * (1 << IDX_W);
	localparam int TAW    = $clog2(TDEPTH);
	localparam int CNTW   = $clog2(NUM_DIGITS + 1);
	localparam int IW     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIG   = 3'd1;
	localparam logic [2:0] ST_PIX   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EVAL  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]            state_q;
	logic [THR_W-1:0]      threshold_q;
	logic [MARGIN_W-1:0]   margin_q;
	logic [SCORE_W-1:0]    accept_q;
	logic [SIZE_W-1:0]     rows_q;
	logic [SIZE_W-1:0]     cols_q;
	logic                  has_black_q;
	logic [DIGIT_W-1:0]    cand_q [NUM_DIGITS];
	logic [CNTW-1:0]       count_q;
	logic [CNTW-1:0]       i_q;
	logic [DIGIT_W-1:0]    dig_q;
	logic signed [PW-1:0]  y_q;
	logic signed [PW-1:0]  x_q;
	logic [COORD_W-1:0]    a_q;
	logic [COORD_W-1:0]    b_q;
	logic [SCORE_W-1:0]    score_q;
	logic [SCORE_W-1:0]    best_q;
	logic [DIGIT_W-1:0]    num_q;
	logic                  acc_q;
	logic                  out_valid_q;
	logic [DIGIT_W-1:0]    out_digit_q;
	logic [SCORE_W-1:0]    out_score_q;
	logic                  out_acc_q;
	logic                  valid_s1;
	logic                  in_cell_s1;

	logic [PIX_W-1:0]      tmpl_mem [TDEPTH];
	logic                  cell_mem [1 << IDX_W];
	logic [PIX_W-1:0]      tmpl_pix_s1;
	logic                  cell_pix_s1;

	logic                  accept;
	logic [COORD_W-1:0]    in_row;
	logic [COORD_W-1:0]    in_col;
	logic                  tmpl_we;
	logic                  cell_we;
	logic                  pix_black;
	logic [TAW-1:0]        tmpl_waddr;
	logic [TAW-1:0]        tmpl_raddr;
	logic [IDX_W-1:0]      cell_raddr;
	logic [SIZE_W-1:0]     tr;
	logic [SIZE_W-1:0]     tc;
	logic signed [PW-1:0]  pos_start;
	logic signed [PW-1:0]  y_end;
	logic signed [PW-1:0]  x_end;
	logic signed [PW-1:0]  y_nxt;
	logic signed [PW-1:0]  x_nxt;
	logic signed [PW-1:0]  ry;
	logic signed [PW-1:0]  rx;
	logic signed [PW-1:0]  cy;
	logic signed [PW-1:0]  cx;
	logic                  in_cell;
	logic                  has_pos;
	logic [DIGIT_W-1:0]    cur_dig;
	logic                  cur_ok;
	logic                  row_last;
	logic                  col_last;
	logic [PIX_W-1:0]      canvas_pix;
	logic                  pix_eq;
	logic                  out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_row    = pixel_index[IDX_W-1:COORD_W];
	assign in_col    = pixel_index[COORD_W-1:0];
	assign pix_black = (pixel_value <= threshold_q);

	assign tmpl_we = accept && (command == CMD_LOAD_TMPL) && (digit != '0) &&
		(digit <= DIGIT_W'(NUM_DIGITS)) &&
		({1'b0, in_row} < SIZE_W'(MAX_TEMPLATE_SIZE)) &&
		({1'b0, in_col} < SIZE_W'(MAX_TEMPLATE_SIZE));
	assign cell_we = accept && (command == CMD_LOAD_CELL) &&
		({1'b0, in_row} < SIZE_W'(CELL_SIZE)) && ({1'b0, in_col} < SIZE_W'(CELL_SIZE));

	assign tmpl_waddr = TAW'({digit - DIGIT_W'(1), pixel_index});
	assign tmpl_raddr = TAW'({dig_q - DIGIT_W'(1), a_q, b_q});

	assign tr = (rows_q > SIZE_W'(MAX_TEMPLATE_SIZE)) ? SIZE_W'(MAX_TEMPLATE_SIZE) : rows_q;
	assign tc = (cols_q > SIZE_W'(MAX_TEMPLATE_SIZE)) ? SIZE_W'(MAX_TEMPLATE_SIZE) : cols_q;

	assign pos_start = PW'(margin_q) + PW'(1);
	assign y_end     = PW'(CANVAS) - PW'(tr) - PW'(margin_q);
	assign x_end     = PW'(CANVAS) - PW'(tc) - PW'(margin_q);
	assign has_pos   = (pos_start < y_end) && (pos_start < x_end);
	assign y_nxt     = y_q + PW'(1);
	assign x_nxt     = x_q + PW'(1);

	assign ry     = y_q + PW'(a_q);
	assign rx     = x_q + PW'(b_q);
	assign cy     = ry - PW'(CELL_SIZE);
	assign cx     = rx - PW'(CELL_SIZE);
	assign in_cell = (ry >= PW'(CELL_SIZE)) && (ry < PW'(2 * CELL_SIZE)) &&
		(rx >= PW'(CELL_SIZE)) && (rx < PW'(2 * CELL_SIZE));
	assign cell_raddr = {cy[COORD_W-1:0], cx[COORD_W-1:0]};

	assign cur_dig  = cand_q[i_q[IW-1:0]];
	assign cur_ok   = (cur_dig != '0) && (cur_dig <= DIGIT_W'(NUM_DIGITS));
	assign row_last = ({1'b0, a_q} == (tr - SIZE_W'(1)));
	assign col_last = ({1'b0, b_q} == (tc - SIZE_W'(1)));

	assign canvas_pix = (in_cell_s1 && !cell_pix_s1) ? PIX_BLACK : PIX_WHITE;
	assign pix_eq     = (tmpl_pix_s1 == canvas_pix);
	assign out_free   = !out_valid_q || !out_stall;

	// template and cell stores with registered read
	always_ff @(posedge clk) begin
		if (tmpl_we) begin
			tmpl_mem[tmpl_waddr] <= pixel_value;
		end
		tmpl_pix_s1 <= tmpl_mem[tmpl_raddr];
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[pixel_index] <= !pix_black;
		end
		cell_pix_s1 <= cell_mem[cell_raddr];
		in_cell_s1  <= in_cell;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			margin_q    <= MARGIN_RST;
			accept_q    <= ACCEPT_RST;
			rows_q      <= ROWS_RST;
			cols_q      <= COLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				REG_MARGIN:    margin_q    <= cfg_data[MARGIN_W-1:0];
				REG_ACCEPT:    accept_q    <= cfg_data[SCORE_W-1:0];
				REG_ROWS:      rows_q      <= cfg_data[SIZE_W-1:0];
				REG_COLS:      cols_q      <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// match sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			has_black_q <= 1'b0;
			for (int k = 0; k < NUM_DIGITS; k++) begin
				cand_q[k] <= DIGIT_W'(k + 1);
			end
			count_q     <= CNTW'(NUM_DIGITS);
			i_q         <= '0;
			dig_q       <= '0;
			y_q         <= '0;
			x_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			score_q     <= '0;
			best_q      <= '0;
			num_q       <= '0;
			acc_q       <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			out_digit_q <= '0;
			out_score_q <= '0;
			out_acc_q   <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_PIX);
			if (valid_s1 && pix_eq) begin
				score_q <= score_q + SCORE_W'(1);
			end
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command)
							CMD_LOAD_CELL: begin
								if (cell_we && pix_black) begin
									has_black_q <= 1'b1;
								end
							end
							CMD_SET_ORDER: begin
								for (int k = 0; k < NUM_DIGITS; k++) begin
									cand_q[k] <= candidate_order[4*k +: 4];
								end
								count_q <= CNTW'(NUM_DIGITS);
							end
							CMD_MATCH: begin
								has_black_q <= 1'b0;
								best_q      <= '0;
								num_q       <= '0;
								acc_q       <= 1'b0;
								i_q         <= '0;
								if (has_black_q && (tr != '0) && (tc != '0) && has_pos) begin
									state_q <= ST_DIG;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIG: begin
					if (i_q >= count_q) begin
						state_q <= ST_DONE;
					end else if (!cur_ok) begin
						i_q <= i_q + CNTW'(1);
					end else begin
						dig_q   <= cur_dig;
						y_q     <= pos_start;
						x_q     <= pos_start;
						a_q     <= '0;
						b_q     <= '0;
						score_q <= '0;
						state_q <= ST_PIX;
					end
				end
				ST_PIX: begin
					if (col_last) begin
						b_q <= '0;
						if (row_last) begin
							a_q     <= '0;
							state_q <= ST_DRAIN;
						end else begin
							a_q <= a_q + COORD_W'(1);
						end
					end else begin
						b_q <= b_q + COORD_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					score_q <= '0;
					if ((score_q > best_q) && (score_q >= accept_q)) begin
						best_q <= score_q;
						num_q  <= dig_q;
						acc_q  <= 1'b1;
						for (int k = 0; k < NUM_DIGITS - 1; k++) begin
							if ((CNTW'(k) >= i_q) && (CNTW'(k + 1) < count_q)) begin
								cand_q[k] <= cand_q[k + 1];
							end
						end
						count_q <= count_q - CNTW'(1);
						state_q <= ST_DONE;
					end else begin
						if (score_q > best_q) begin
							best_q <= score_q;
							num_q  <= dig_q;
						end
						state_q <= ST_PIX;
						if (x_nxt < x_end) begin
							x_q <= x_nxt;
						end else begin
							x_q <= pos_start;
							if (y_nxt < y_end) begin
								y_q <= y_nxt;
							end else begin
								i_q     <= i_q + CNTW'(1);
								state_q <= ST_DIG;
							end
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_digit_q <= num_q;
						out_score_q <= best_q;
						out_acc_q   <= acc_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign best_digit     = out_digit_q;
	assign best_score     = out_score_q;
	assign accepted_early = out_acc_q;

endmodule
